/* rtl/utf8d_pkg.sv */
package utf8d_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned UsedWidth = 3;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

  // sequence lengths, held in the state register and given as bytes used
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenOne  = 3'd1;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThr  = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  typedef struct packed {
    logic [2:0]         seq_len;
    logic [1:0]         conts;
    logic [CpWidth-1:0] accum;
  } seq_t;

  // results caused by one input byte: err_cnt replacements, then optionally one final result
  typedef struct packed {
    logic [1:0]           err_cnt;
    logic                 fin_valid;
    logic [CpWidth-1:0]   fin_cp;
    logic [UsedWidth-1:0] fin_used;
  } run_t;

endpackage

/* rtl/utf8_stream_decoder_unit.sv */
// UTF-8 stream decoder: takes one byte per beat and gives one code point per output beat.
// While the output is not stalled, a byte is accepted every cycle when it causes at most
// one result, and the result register sends one per cycle; a byte that ends a broken or
// truncated sequence causes up to four results (replacements first, then its own result),
// and the input stalls until the last is sent. Decoder state moves on per accepted byte.
module utf8_stream_decoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       in_byte_i,
  input  logic                             buffer_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [utf8d_pkg::CpWidth-1:0]    code_point_o,
  output logic [utf8d_pkg::UsedWidth-1:0]  bytes_used_o,
  output logic                             run_last_o
);
  import utf8d_pkg::*;

  seq_t seq_q, seq_d;
  run_t run_q, run_d, step_run;
  logic in_take;
  logic out_take;

  utf8d_step u_step (
    .seq_i       (seq_q),
    .in_byte_i   (in_byte_i),
    .buffer_end_i(buffer_end_i),
    .seq_o       (seq_d),
    .run_o       (step_run)
  );

  assign out_valid_o  = (run_q.err_cnt != 2'd0) || run_q.fin_valid;
  assign run_last_o   = (run_q.err_cnt == 2'd0) || (run_q.err_cnt == 2'd1 && !run_q.fin_valid);
  assign code_point_o = (run_q.err_cnt != 2'd0) ? Replacement : run_q.fin_cp;
  assign bytes_used_o = (run_q.err_cnt != 2'd0) ? LenOne : run_q.fin_used;

  assign out_take   = out_valid_o && !out_stall_i;
  // the run register frees up on the beat that sends its last result
  assign in_stall_o = out_valid_o && !(out_take && run_last_o);
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    run_d = run_q;
    if (in_take) begin
      run_d = step_run;
    end else if (out_take) begin
      if (run_q.err_cnt != 2'd0) begin
        run_d.err_cnt = run_q.err_cnt - 2'd1;
      end else begin
        run_d.fin_valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
      run_q <= '0;
    end else begin
      if (in_take) begin
        seq_q <= seq_d;
      end
      run_q <= run_d;
    end
  end

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !run_last_o |=> out_valid_o)
    else $error("run ended before its last result");

  a_take_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> (!out_valid_o || (out_take && run_last_o)))
    else $error("byte accepted while results still pending");

  a_multi_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bytes_used_o != LenOne |-> run_last_o)
    else $error("multi-byte result not alone in its run");

  a_err_replacement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> code_point_o == Replacement && bytes_used_o == LenOne)
    else $error("leading result of a run is not a replacement");

endmodule

/* rtl/utf8d_step.sv */
module utf8d_step (
  input  utf8d_pkg::seq_t seq_i,
  input  logic [7:0]      in_byte_i,
  input  logic            buffer_end_i,
  output utf8d_pkg::seq_t seq_o,
  output utf8d_pkg::run_t run_o
);
  import utf8d_pkg::*;

  logic       pending;
  logic       is_cont;
  logic [2:0] conts_inc;
  logic [2:0] lead_len;
  logic [CpWidth-1:0] lead_bits;
  logic [CpWidth-1:0] accum_ext;

  assign pending   = (seq_i.seq_len >= LenTwo) && (seq_i.seq_len <= LenFour);
  assign is_cont   = (in_byte_i[7:6] == 2'b10);
  assign conts_inc = {1'b0, seq_i.conts} + 3'd1;
  assign accum_ext = {seq_i.accum[CpWidth-7:0], in_byte_i[5:0]};

  always_comb begin
    priority if (in_byte_i[7:5] == 3'b110) begin
      lead_len  = LenTwo;
      lead_bits = {16'd0, in_byte_i[4:0]};
    end else if (in_byte_i[7:4] == 4'b1110) begin
      lead_len  = LenThr;
      lead_bits = {17'd0, in_byte_i[3:0]};
    end else if (in_byte_i[7:3] == 5'b11110) begin
      lead_len  = LenFour;
      lead_bits = {18'd0, in_byte_i[2:0]};
    end else begin
      lead_len  = LenNone;
      lead_bits = '0;
    end
  end

  always_comb begin
    seq_o = '0;
    run_o = '0;
    if (pending && is_cont) begin
      if ((conts_inc + 3'd1) >= seq_i.seq_len) begin
        run_o.fin_valid = 1'b1;
        run_o.fin_cp    = accum_ext;
        run_o.fin_used  = seq_i.seq_len;
      end else if (buffer_end_i) begin
        // truncated at buffer end: lead plus every continuation so far
        run_o.err_cnt = 2'(conts_inc + 3'd1);
      end else begin
        seq_o.seq_len = seq_i.seq_len;
        seq_o.conts   = conts_inc[1:0];
        seq_o.accum   = accum_ext;
      end
    end else begin
      if (pending) begin
        run_o.err_cnt = 2'(conts_inc);
      end
      if (!in_byte_i[7]) begin
        run_o.fin_valid = 1'b1;
        run_o.fin_cp    = {13'd0, in_byte_i};
        run_o.fin_used  = LenOne;
      end else if (lead_len == LenNone || buffer_end_i) begin
        run_o.fin_valid = 1'b1;
        run_o.fin_cp    = Replacement;
        run_o.fin_used  = LenOne;
      end else begin
        seq_o.seq_len = lead_len;
        seq_o.accum   = lead_bits;
      end
    end
  end

endmodule
